// ===== rtl/sesb_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sesb_pkg
// Shared types and constants of the spring edge stiffness block.
// ---------------------------------------------------------------------------
package sesb_pkg;

    localparam int NODE_W   = 10;
    localparam int POS_W    = 32;
    localparam int ENTRY_W  = 31;
    localparam int CFG_AW   = 2;
    localparam int CFG_DW   = 32;

    // register byte addresses
    localparam logic [CFG_AW-1:0] ADDR_UNIFORM_K = 2'd0;

    localparam logic [ENTRY_W-1:0] ENTRY_MAX = {ENTRY_W{1'b1}};

    // one spring edge
    typedef struct packed {
        logic [NODE_W-1:0]       master_node;
        logic [NODE_W-1:0]       slave_node;
        logic signed [POS_W-1:0] master_x;
        logic signed [POS_W-1:0] master_y;
        logic signed [POS_W-1:0] slave_x;
        logic signed [POS_W-1:0] slave_y;
        logic [31:0]             stiffness;
        logic [31:0]             rest_len;
        logic                    last_edge;
    } t_in;

    // one tangent block
    typedef struct packed {
        logic [NODE_W-1:0]  out_master;
        logic [NODE_W-1:0]  out_slave;
        logic [ENTRY_W-1:0] k_xx;
        logic [ENTRY_W-1:0] k_xy;
        logic [ENTRY_W-1:0] k_yy;
        logic               zero_length;
        logic               out_last;
    } t_out;

endpackage

// ===== rtl/spring_edge_stiffness_block.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spring_edge_stiffness_block
// 2-D linear spring tangent stiffness block, one edge per clock, Q16.16.
// ---------------------------------------------------------------------------
// Usage: one edge may be started in every cycle (busy is always low) and its
// result appears exactly 102 cycles later as a single-cycle o_valid pulse that
// the receiver must take; results come out in start order. The latency is set
// by the bit-serial pipelines: 32 stages of square root, then 64 stages of the
// k*L/R quotient, with the three direction ratios computed alongside, plus
// three front stages (difference, squares, sum) and three back stages
// (two multiply/add steps and the saturating output register).
// ---------------------------------------------------------------------------
module spring_edge_stiffness_block (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  sesb_pkg::t_in                 i_data,
    output logic                          o_valid,
    output sesb_pkg::t_out                o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sesb_pkg::CFG_AW-1:0]   paddr,
    input  logic [sesb_pkg::CFG_DW-1:0]   pwdata,
    output logic [sesb_pkg::CFG_DW-1:0]   prdata,
    output logic                          pready
);
    import sesb_pkg::*;

    localparam int SQ_STEPS = 32;
    localparam int G_STEPS  = 64;
    localparam int RT_STEPS = 33;
    localparam int NSTEP    = SQ_STEPS + G_STEPS;
    localparam int LATENCY  = NSTEP + 6;

    // fields that ride along every stage
    typedef struct packed {
        logic [NODE_W-1:0] master;
        logic [NODE_W-1:0] slave;
        logic              last;
        logic              zero;
        logic              pos;
        logic [31:0]       k;
    } t_tag;

    typedef struct packed {
        t_tag        tag;
        logic        sh;
        logic [31:0] len;
        logic [30:0] ax;
        logic [30:0] ay;
    } t_s0;

    typedef struct packed {
        t_tag        tag;
        logic        sh;
        logic [63:0] kl;
        logic [61:0] xx;
        logic [61:0] yy;
        logic [61:0] xy;
    } t_s1;

    typedef struct packed {
        logic [32:0] q;
        logic [63:0] rem;
    } t_rat;

    typedef struct packed {
        t_tag        tag;
        logic        sh;
        logic [63:0] kl;
        logic [63:0] sum;
        logic [63:0] srem;
        logic [31:0] root;
        logic [32:0] rdiv;
        logic [63:0] gq;
        logic [33:0] grem;
        t_rat        fxx;
        t_rat        fyy;
        t_rat        fxy;
    } t_work;

    typedef struct packed {
        t_tag        tag;
        logic [64:0] hxx, lxx;
        logic [64:0] hyy, lyy;
        logic [64:0] hxy, lxy;
    } t_m1;

    typedef struct packed {
        t_tag        tag;
        logic [64:0] pxx;
        logic [64:0] pyy;
        logic [64:0] pxy;
    } t_m2;

    // one restoring step of a fraction num/den
    function automatic t_rat f_rat(input t_rat a, input logic [63:0] den, input logic first);
        t_rat o;
        o.rem = first ? a.rem : {a.rem[62:0], 1'b0};
        o.q   = first ? a.q : {a.q[31:0], 1'b0};
        if (o.rem >= den) begin
            o.rem = o.rem - den;
            o.q   = o.q | 33'd1;
        end
        return o;
    endfunction

    // one pipeline step: sqrt bit, quotient bit, ratio bits
    function automatic t_work f_step(input t_work w, input int s);
        t_work       o;
        logic [63:0] t;
        logic [63:0] kb;
        logic [33:0] dr;
        o = w;
        if (s < SQ_STEPS) begin
            t = ({32'd0, w.root} << (SQ_STEPS - s)) + (64'd1 << (2 * (SQ_STEPS - 1 - s)));
            if (w.srem >= t) begin
                o.srem = w.srem - t;
                o.root = w.root | (32'd1 << (SQ_STEPS - 1 - s));
            end
            if (s == SQ_STEPS - 1) begin
                o.rdiv = {1'b0, o.root} << w.sh;
                if (o.rdiv == 33'd0) begin
                    o.rdiv = 33'd1;
                end
            end
        end else begin
            kb = w.kl >> (G_STEPS - 1 - (s - SQ_STEPS));
            dr = {w.grem[32:0], kb[0]};
            if (dr >= {1'b0, w.rdiv}) begin
                dr   = dr - {1'b0, w.rdiv};
                o.gq = w.gq | (64'd1 << (G_STEPS - 1 - (s - SQ_STEPS)));
            end
            o.grem = dr;
        end
        if (s < RT_STEPS) begin
            o.fxx = f_rat(w.fxx, w.sum, s == 0);
            o.fyy = f_rat(w.fyy, w.sum, s == 0);
            o.fxy = f_rat(w.fxy, w.sum, s == 0);
        end
        return o;
    endfunction

    logic              w_uniform_k;
    logic [31:0]       r_ustiff;
    logic              w_accept;
    logic [LATENCY-1:0] r_vld;
    t_s0               r_s0, n_s0;
    t_s1               r_s1;
    t_work             r_pipe [0:NSTEP];
    t_work             n_pipe [0:NSTEP-1];
    t_m1               r_m1;
    t_m2               r_m2;
    t_out              r_out, n_out;
    logic signed [32:0] w_dx, w_dy;
    logic [32:0]       w_ax, w_ay;
    logic              w_big;

    // configuration port
    assign pready = 1'b1;
    assign prdata = r_ustiff;
    assign w_uniform_k = (r_ustiff != 32'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ustiff <= '0;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_UNIFORM_K) begin
            r_ustiff <= pwdata;
        end
    end

    // transaction handshake and valid line
    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign o_valid  = r_vld[LATENCY-1];
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LATENCY-2:0], w_accept};
        end
    end

    // stage 0: differences, magnitudes, range shift
    always_comb begin
        w_dx = $signed({i_data.slave_x[31], i_data.slave_x})
             - $signed({i_data.master_x[31], i_data.master_x});
        w_dy = $signed({i_data.slave_y[31], i_data.slave_y})
             - $signed({i_data.master_y[31], i_data.master_y});
        w_ax = w_dx[32] ? 33'(-w_dx) : w_dx;
        w_ay = w_dy[32] ? 33'(-w_dy) : w_dy;
        w_big = w_ax[32] | w_ax[31] | w_ay[32] | w_ay[31];
        n_s0.tag.master = i_data.master_node;
        n_s0.tag.slave  = i_data.slave_node;
        n_s0.tag.last   = i_data.last_edge;
        n_s0.tag.zero   = (w_dx == 33'sd0) && (w_dy == 33'sd0);
        n_s0.tag.pos    = (w_dx != 33'sd0) && (w_dy != 33'sd0) && (w_dx[32] == w_dy[32]);
        n_s0.tag.k      = w_uniform_k ? r_ustiff : i_data.stiffness;
        n_s0.sh         = w_big;
        n_s0.len        = i_data.rest_len;
        n_s0.ax         = w_big ? w_ax[31:1] : w_ax[30:0];
        n_s0.ay         = w_big ? w_ay[31:1] : w_ay[30:0];
    end

    always_ff @(posedge i_clk) begin
        r_s0 <= n_s0;
    end

    // stage 1: squares, cross product, k*L
    always_ff @(posedge i_clk) begin
        r_s1.tag <= r_s0.tag;
        r_s1.sh  <= r_s0.sh;
        r_s1.kl  <= {32'd0, r_s0.tag.k} * {32'd0, r_s0.len};
        r_s1.xx  <= {31'd0, r_s0.ax} * {31'd0, r_s0.ax};
        r_s1.yy  <= {31'd0, r_s0.ay} * {31'd0, r_s0.ay};
        r_s1.xy  <= {31'd0, r_s0.ax} * {31'd0, r_s0.ay};
    end

    // serial sqrt, quotient and ratio steps
    always_comb begin
        for (int s = 0; s < NSTEP; s++) begin
            n_pipe[s] = f_step(r_pipe[s], s);
        end
    end

    // stage 2: squared length, serial units loaded; then the serial stages
    always_ff @(posedge i_clk) begin
        r_pipe[0].tag     <= r_s1.tag;
        r_pipe[0].sh      <= r_s1.sh;
        r_pipe[0].kl      <= r_s1.kl;
        r_pipe[0].sum     <= {2'd0, r_s1.xx} + {2'd0, r_s1.yy};
        r_pipe[0].srem    <= {2'd0, r_s1.xx} + {2'd0, r_s1.yy};
        r_pipe[0].root    <= '0;
        r_pipe[0].rdiv    <= '0;
        r_pipe[0].gq      <= '0;
        r_pipe[0].grem    <= '0;
        r_pipe[0].fxx.q   <= '0;
        r_pipe[0].fxx.rem <= {2'd0, r_s1.yy};
        r_pipe[0].fyy.q   <= '0;
        r_pipe[0].fyy.rem <= {2'd0, r_s1.xx};
        r_pipe[0].fxy.q   <= '0;
        r_pipe[0].fxy.rem <= {2'd0, r_s1.xy};
        for (int s = 0; s < NSTEP; s++) begin
            r_pipe[s+1] <= n_pipe[s];
        end
    end

    // partial products of G times each ratio
    always_ff @(posedge i_clk) begin
        r_m1.tag <= r_pipe[NSTEP].tag;
        r_m1.hxx <= {1'b0, r_pipe[NSTEP].gq[63:32]} * {32'd0, r_pipe[NSTEP].fxx.q};
        r_m1.lxx <= {1'b0, r_pipe[NSTEP].gq[31:0]}  * {32'd0, r_pipe[NSTEP].fxx.q};
        r_m1.hyy <= {1'b0, r_pipe[NSTEP].gq[63:32]} * {32'd0, r_pipe[NSTEP].fyy.q};
        r_m1.lyy <= {1'b0, r_pipe[NSTEP].gq[31:0]}  * {32'd0, r_pipe[NSTEP].fyy.q};
        r_m1.hxy <= {1'b0, r_pipe[NSTEP].gq[63:32]} * {32'd0, r_pipe[NSTEP].fxy.q};
        r_m1.lxy <= {1'b0, r_pipe[NSTEP].gq[31:0]}  * {32'd0, r_pipe[NSTEP].fxy.q};
    end

    // combine partial products
    always_ff @(posedge i_clk) begin
        r_m2.tag <= r_m1.tag;
        r_m2.pxx <= r_m1.hxx + (r_m1.lxx >> 32);
        r_m2.pyy <= r_m1.hyy + (r_m1.lyy >> 32);
        r_m2.pxy <= r_m1.hxy + (r_m1.lxy >> 32);
    end

    // clamp at zero, saturate, output register
    always_comb begin
        logic [31:0] d;
        d = '0;
        n_out.out_master  = r_m2.tag.master;
        n_out.out_slave   = r_m2.tag.slave;
        n_out.zero_length = r_m2.tag.zero;
        n_out.out_last    = r_m2.tag.last;
        if (r_m2.pxx >= {33'd0, r_m2.tag.k}) begin
            n_out.k_xx = '0;
        end else begin
            d = r_m2.tag.k - r_m2.pxx[31:0];
            n_out.k_xx = d[31] ? ENTRY_MAX : d[30:0];
        end
        if (r_m2.pyy >= {33'd0, r_m2.tag.k}) begin
            n_out.k_yy = '0;
        end else begin
            d = r_m2.tag.k - r_m2.pyy[31:0];
            n_out.k_yy = d[31] ? ENTRY_MAX : d[30:0];
        end
        if (!r_m2.tag.pos) begin
            n_out.k_xy = '0;
        end else if (r_m2.pxy > {34'd0, ENTRY_MAX}) begin
            n_out.k_xy = ENTRY_MAX;
        end else begin
            n_out.k_xy = r_m2.pxy[30:0];
        end
        if (r_m2.tag.zero) begin
            n_out.k_xx = '0;
            n_out.k_xy = '0;
            n_out.k_yy = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

`ifndef SYNTHESIS
    // every started edge comes out after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LATENCY o_valid)
        else $error("result missing after pipeline latency");

    // coinciding ends give an all-zero block
    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.zero_length) |->
        (o_result.k_xx == '0 && o_result.k_xy == '0 && o_result.k_yy == '0))
        else $error("nonzero entry on zero-length edge");

    // no result without a matching start
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept, LATENCY))
        else $error("result without a started edge");
`endif

endmodule
